// ----- sv/ptg_pkg.sv -----
// package for the prime table generator
// holds field widths, default sizes and the seed constants
// no dependencies
package ptg_pkg;

	localparam int INDEX_WIDTH       = 11;
	localparam int OUT_WIDTH         = 32;
	localparam int TABLE_DEPTH_DEF   = 1024;
	localparam int PRIME_WIDTH_DEF   = 32;
	localparam int FIRST_PRIME       = 2;
	localparam int FIRST_CANDIDATE   = 3;
	localparam int CANDIDATE_STEP    = 2;

endpackage

// ----- sv/ptg_divider.sv -----
// bit-serial restoring divider for the prime table generator
// one quotient bit per cycle, WIDTH quotient bits per division
// depends on ptg_pkg for the default width
module ptg_divider #(
	parameter int WIDTH = ptg_pkg::PRIME_WIDTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [WIDTH-1:0] dividend,
	input  logic [WIDTH-1:0] divisor,
	output logic             done,
	output logic [WIDTH-1:0] quotient,
	output logic [WIDTH-1:0] remainder
);
	import ptg_pkg::*;

	localparam int CNT_W = $clog2(WIDTH + 1);

	logic [WIDTH-1:0] rem_q;
	logic [WIDTH-1:0] quo_q;
	logic [WIDTH-1:0] dsr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             run_q;
	logic             done_q;
	logic [WIDTH:0]   shifted;
	logic [WIDTH:0]   diff;

	// next dividend bit enters the partial remainder from the top of the quotient shifter
	assign shifted = {rem_q, quo_q[WIDTH-1]};
	assign diff    = shifted - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(WIDTH);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (run_q) begin
			if (!diff[WIDTH]) begin
				rem_q <= diff[WIDTH-1:0];
				quo_q <= {quo_q[WIDTH-2:0], 1'b1};
			end else begin
				rem_q <= shifted[WIDTH-1:0];
				quo_q <= {quo_q[WIDTH-2:0], 1'b0};
			end
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

// ----- sv/prime_table_generator_top.sv -----
// prime table generator: a table hit answers through the check, read and output states; extension tests odd
// candidates by trial division against the stored primes in the bit-serial divider, then
// appends the candidate or advances to the next one, so a request that extends the table
// answers only after that work; bad indexes answer in the next cycle
// reset sets the table length to one (entry 0 reads as 2) and the candidate to 3,
// the prime store itself is not cleared; results are one-cycle strobes on done
module prime_table_generator_top #(
	parameter int TABLE_DEPTH = ptg_pkg::TABLE_DEPTH_DEF,
	parameter int PRIME_WIDTH = ptg_pkg::PRIME_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [ptg_pkg::INDEX_WIDTH-1:0] prime_index,
	output logic                            done,
	output logic [ptg_pkg::OUT_WIDTH-1:0]   prime_value,
	output logic                            index_error
);
	import ptg_pkg::*;

	localparam int AW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW   = $clog2(TABLE_DEPTH + 1);
	localparam int CMPW = ((CW > INDEX_WIDTH) ? CW : INDEX_WIDTH) + 1;

	typedef enum logic [8:0] {
		S_IDLE   = 9'b000000001,
		S_CHECK  = 9'b000000010,
		S_DIV_RD = 9'b000000100,
		S_DIV_LD = 9'b000001000,
		S_DIV_RUN= 9'b000010000,
		S_APPEND = 9'b000100000,
		S_ADVANCE= 9'b001000000,
		S_OUT_RD = 9'b010000000,
		S_OUT    = 9'b100000000
	} state_t;

	state_t                 state_q;
	logic [INDEX_WIDTH-1:0] idx_q;
	logic [CW-1:0]          found_q;
	logic [PRIME_WIDTH-1:0] cand_q;
	logic                   exhausted_q;
	logic [AW-1:0]          div_i_q;
	logic [PRIME_WIDTH-1:0] divisor_q;
	logic                   done_q;
	logic                   err_q;
	logic [OUT_WIDTH-1:0]   value_q;

	logic [PRIME_WIDTH-1:0] mem [TABLE_DEPTH];
	logic [PRIME_WIDTH-1:0] rd_data_q;
	logic                   rd_zero_q;
	logic [AW-1:0]          rd_addr;
	logic [AW-1:0]          out_addr;
	logic [PRIME_WIDTH-1:0] rd_prime;

	logic                   div_start;
	logic                   div_done;
	logic [PRIME_WIDTH-1:0] div_quo;
	logic [PRIME_WIDTH-1:0] div_rem;

	logic                   idx_bad;
	logic                   table_hit;
	logic                   last_divisor;
	logic                   cand_last;

	assign idx_bad      = (prime_index == '0) ||
	                      (CMPW'(prime_index) > CMPW'(TABLE_DEPTH));
	assign table_hit    = CMPW'(found_q) >= CMPW'(idx_q);
	assign last_divisor = (CW'(div_i_q) + CW'(1)) >= found_q;
	// odd candidate at the top of the range: stepping by two would wrap
	assign cand_last    = cand_q > ({PRIME_WIDTH{1'b1}} - PRIME_WIDTH'(CANDIDATE_STEP));
	assign out_addr     = AW'(idx_q - INDEX_WIDTH'(1));
	assign rd_addr      = (state_q == S_CHECK || state_q == S_OUT_RD) ? out_addr : div_i_q;
	// entry 0 is the seed and is never written
	assign rd_prime     = rd_zero_q ? PRIME_WIDTH'(FIRST_PRIME) : rd_data_q;
	assign div_start    = (state_q == S_DIV_LD) && (rd_prime != '0);

	always_ff @(posedge clk) begin
		if (state_q == S_APPEND) begin
			mem[found_q[AW-1:0]] <= cand_q;
		end
		rd_data_q <= mem[rd_addr];
		rd_zero_q <= (rd_addr == '0);
	end

	ptg_divider #(
		.WIDTH(PRIME_WIDTH)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (cand_q),
		.divisor  (rd_prime),
		.done     (div_done),
		.quotient (div_quo),
		.remainder(div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			found_q     <= CW'(1);
			cand_q      <= PRIME_WIDTH'(FIRST_CANDIDATE);
			exhausted_q <= 1'b0;
			done_q      <= 1'b0;
			div_i_q     <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						if (idx_bad) begin
							done_q <= 1'b1;
						end else begin
							state_q <= S_CHECK;
						end
					end
				end
				S_CHECK: begin
					if (table_hit) begin
						state_q <= S_OUT_RD;
					end else if (exhausted_q) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						div_i_q <= '0;
						state_q <= S_DIV_RD;
					end
				end
				S_DIV_RD: begin
					state_q <= S_DIV_LD;
				end
				S_DIV_LD: begin
					state_q <= (rd_prime == '0) ? S_APPEND : S_DIV_RUN;
				end
				S_DIV_RUN: begin
					if (div_done) begin
						if (div_rem == '0) begin
							state_q <= S_ADVANCE;
						end else if (div_quo <= divisor_q || last_divisor) begin
							state_q <= S_APPEND;
						end else begin
							div_i_q <= div_i_q + 1'b1;
							state_q <= S_DIV_RD;
						end
					end
				end
				S_APPEND: begin
					found_q <= found_q + 1'b1;
					state_q <= S_ADVANCE;
				end
				S_ADVANCE: begin
					if (cand_last) begin
						exhausted_q <= 1'b1;
					end else begin
						cand_q <= cand_q + PRIME_WIDTH'(CANDIDATE_STEP);
					end
					state_q <= S_CHECK;
				end
				S_OUT_RD: begin
					state_q <= S_OUT;
				end
				S_OUT: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// result payload, the requested position and the divisor held for the quotient test
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			idx_q <= prime_index;
		end
		if (state_q == S_DIV_LD) begin
			divisor_q <= rd_prime;
		end
		if (state_q == S_IDLE && start && idx_bad) begin
			err_q   <= 1'b1;
			value_q <= '0;
		end else if (state_q == S_CHECK && !table_hit && exhausted_q) begin
			err_q   <= 1'b1;
			value_q <= '0;
		end else if (state_q == S_OUT) begin
			err_q   <= 1'b0;
			value_q <= OUT_WIDTH'(rd_prime);
		end
	end

	assign busy        = (state_q != S_IDLE);
	assign done        = done_q;
	assign prime_value = value_q;
	assign index_error = err_q;

	a_bad_index_answers: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && prime_index == '0) |=> (done && index_error))
		else $error("zero index not answered with an error next cycle");

	a_error_zero_value: assert property (@(posedge clk) disable iff (!arst_n)
		(done && index_error) |-> (prime_value == '0))
		else $error("error result carries a non-zero value");

	a_found_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(found_q != '0) && (CMPW'(found_q) <= CMPW'(TABLE_DEPTH)))
		else $error("table length out of range");

	a_candidate_odd: assert property (@(posedge clk) disable iff (!arst_n)
		cand_q[0])
		else $error("candidate became even");

	a_append_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_APPEND) |=> (found_q == $past(found_q) + 1'b1))
		else $error("append did not grow the table");

endmodule
